>>> sv/scan_code_to_ascii_decoder_unit_assert.svh
// ----------------------------------------------------------------------------
// Scan code decoder assertion macros
// Clocked property shorthands shared by the decoder RTL.
// ----------------------------------------------------------------------------
`ifndef SCAN_CODE_TO_ASCII_DECODER_UNIT_ASSERT_SVH
`define SCAN_CODE_TO_ASCII_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SCAD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SCAD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/scad_pkg.sv
// ----------------------------------------------------------------------------
// Scan code decoder package
// Scan codes, modifier flag and result types, and the ASCII key tables.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package scad_pkg;

  localparam int KeyCount = 58;

  localparam logic [7:0] SC_SHIFT_L_MAKE  = 8'h2A;
  localparam logic [7:0] SC_SHIFT_L_BREAK = 8'hAA;
  localparam logic [7:0] SC_SHIFT_R_MAKE  = 8'h36;
  localparam logic [7:0] SC_SHIFT_R_BREAK = 8'hB6;
  localparam logic [7:0] SC_CTRL_MAKE     = 8'h1D;
  localparam logic [7:0] SC_CTRL_BREAK    = 8'h9D;
  localparam logic [7:0] SC_ALT_MAKE      = 8'h38;
  localparam logic [7:0] SC_ALT_BREAK     = 8'hB8;
  localparam logic [7:0] SC_ESCAPE        = 8'hE0;
  localparam logic [7:0] SC_DELETE_MAKE   = 8'h53;
  localparam logic [7:0] SC_DELETE_BREAK  = 8'hD3;

  typedef struct packed {
    logic del;
    logic esc;
    logic alt;
    logic ctrl;
    logic shift;
  } flags_t;

  typedef struct packed {
    logic       has_char;
    logic [6:0] char_code;
    logic       shift_held;
    logic       ctrl_held;
    logic       alt_held;
    logic       delete_held;
  } result_t;

  localparam logic [6:0] PLAIN_KEYS [KeyCount] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38,
    7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70,
    7'h5B, 7'h5D, 7'h0A,
    7'h00,
    7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60,
    7'h00,
    7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E,
    7'h2F,
    7'h00, 7'h2A, 7'h00, 7'h20
  };

  localparam logic [6:0] SHIFTED_KEYS [KeyCount] = '{
    7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A,
    7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
    7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50,
    7'h7B, 7'h7D, 7'h0A,
    7'h00,
    7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E,
    7'h00,
    7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E,
    7'h3F,
    7'h00, 7'h2A, 7'h00, 7'h20
  };

  // Look up a make code; codes past the table give NUL.
  function automatic logic [6:0] key_lookup(input logic [7:0] code, input logic shift);
    logic [6:0] ch;
    ch = 7'h00;
    if (code < 8'(KeyCount)) begin
      ch = shift ? SHIFTED_KEYS[code[5:0]] : PLAIN_KEYS[code[5:0]];
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

>>> sv/scad_decode.sv
// ----------------------------------------------------------------------------
// Scan code decode step
// Flag update and ASCII lookup for one scan code byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scad_decode (
  input  wire logic [7:0]       scan_code,
  input  wire scad_pkg::flags_t flags,
  output scad_pkg::flags_t      flags_next,
  output scad_pkg::result_t     result
);
  import scad_pkg::*;

  logic consumed;

  always_comb begin
    flags_next = flags;
    consumed   = 1'b1;
    if (flags.esc) begin
      if (scan_code == SC_DELETE_MAKE) begin
        flags_next.del = 1'b1;
      end else if (scan_code == SC_DELETE_BREAK) begin
        flags_next.del = 1'b0;
      end
      flags_next.esc = 1'b0;
    end else begin
      case (scan_code)
        SC_SHIFT_L_MAKE, SC_SHIFT_R_MAKE:   flags_next.shift = 1'b1;
        SC_SHIFT_L_BREAK, SC_SHIFT_R_BREAK: flags_next.shift = 1'b0;
        SC_CTRL_MAKE:                       flags_next.ctrl  = 1'b1;
        SC_CTRL_BREAK:                      flags_next.ctrl  = 1'b0;
        SC_ALT_MAKE:                        flags_next.alt   = 1'b1;
        SC_ALT_BREAK:                       flags_next.alt   = 1'b0;
        SC_ESCAPE:                          flags_next.esc   = 1'b1;
        default:                            consumed         = 1'b0;
      endcase
    end
  end

  always_comb begin
    result.has_char    = ~consumed & ~scan_code[7];
    result.char_code   = result.has_char ? key_lookup(scan_code, flags_next.shift) : 7'h00;
    result.shift_held  = flags_next.shift;
    result.ctrl_held   = flags_next.ctrl;
    result.alt_held    = flags_next.alt;
    result.delete_held = flags_next.del;
  end

endmodule

`default_nettype wire

>>> sv/scan_code_to_ascii_decoder_unit.sv
// ----------------------------------------------------------------------------
// Scan code to ASCII decoder
// Translates set-1 keyboard scan codes to ASCII and tracks modifier keys.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid / in_stall with scan_code, one raw set-1 byte
//   per transfer. Output channel: out_valid / out_stall with has_char,
//   char_code and the shift, ctrl, alt and delete flags after that byte.
//   Every input transfer yields exactly one output transfer, in order.
//   Each result is registered. Throughput: one byte per cycle while
//   in_stall is low; the decode is a single flag update and a 58-entry
//   table lookup between the input port and the result register.
//   A skid register behind the result register lets the block take one more
//   byte while the receiver stalls; with both full, in_stall rises and holds
//   until the receiver takes the waiting result.
//   Reset (rst, synchronous, active high): clear all modifier flags, drop
//   both result entries and release in_stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "scan_code_to_ascii_decoder_unit_assert.svh"

module scan_code_to_ascii_decoder_unit (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] scan_code,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            has_char,
  output logic [6:0]      char_code,
  output logic            shift_held,
  output logic            ctrl_held,
  output logic            alt_held,
  output logic            delete_held
);
  import scad_pkg::*;

  flags_t  flags;
  flags_t  flags_next;
  result_t result_next;
  result_t out_data;
  result_t skid_data;
  logic    skid_valid;
  logic    in_xfer;
  logic    out_free;

  // Decode the incoming byte against the current flags.
  scad_decode u_decode (
    .scan_code  (scan_code),
    .flags      (flags),
    .flags_next (flags_next),
    .result     (result_next)
  );

  // Stall the sender only when the skid entry is occupied.
  assign in_stall = skid_valid;
  assign in_xfer  = in_valid & ~in_stall;
  // Result register can load when empty or being taken this cycle.
  assign out_free = ~out_valid | ~out_stall;

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      flags      <= '0;
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (in_xfer) begin
        flags <= flags_next;
      end
      if (out_free) begin
        // Drain the skid entry first; it is older than any new byte.
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= in_xfer;
        end
      end else if (in_xfer) begin
        skid_valid <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (in_xfer) begin
        out_data <= result_next;
      end
    end else if (in_xfer) begin
      skid_data <= result_next;
    end
  end

  assign has_char    = out_data.has_char;
  assign char_code   = out_data.char_code;
  assign shift_held  = out_data.shift_held;
  assign ctrl_held   = out_data.ctrl_held;
  assign alt_held    = out_data.alt_held;
  assign delete_held = out_data.delete_held;

  `SCAD_ASSERT_NOW(a_nul_without_char, out_valid && !has_char, char_code == 7'h00, "char_code set without a character")
  `SCAD_ASSERT_NOW(a_skid_behind_out, skid_valid, out_valid, "skid entry held with empty result register")
  `SCAD_ASSERT_NEXT(a_skid_drains, skid_valid && !out_stall, !skid_valid, "skid entry did not drain")
  `SCAD_ASSERT_NEXT(a_escape_one_byte, flags.esc && in_xfer, !flags.esc, "escape prefix outlived its byte")

endmodule

`default_nettype wire
